### design/assert_macros.svh
// assertion macros used by the stack rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LSWP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// condition must never be seen at a clock edge outside reset
`define LSWP_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error(msg);

`endif

### design/lswp_pkg.sv
// types and constants of the lifo stack with peek
`default_nettype none

package lswp_pkg;

	// requested operation
	typedef enum logic [1:0] {
		MODE_PUSH = 2'd0,
		MODE_POP  = 2'd1,
		MODE_PEEK = 2'd2,
		MODE_NOP  = 2'd3
	} mode_e_t;

	// result status
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_BADPOS    = 2'd3
	} status_t;

	localparam int WORD_W  = 32;
	localparam int COUNT_W = 5;
	localparam int POS_W   = 5;

	localparam logic [WORD_W-1:0] ERR_WORD = '1;

	// result info that travels from the access stage to the output register
	typedef struct packed {
		logic                use_mem;
		status_t             status;
		logic [COUNT_W-1:0]  count;
		logic                empty;
		logic                full;
	} res_info_t;

endpackage

`default_nettype wire

### design/lifo_stack_with_peek_core.sv
// top level of the lifo stack with peek
`default_nettype none

// Stack of DEPTH signed 32-bit words kept in one synchronous memory. Each
// request (push, pop, peek by 1-based position from the top) passes the
// access stage, where the fill count is updated and the memory is written
// or read, and its result then leaves through an output register, so one
// request is taken per clock while in_stall is low. The count advances at
// the transfer itself and each request reads only entries written by
// earlier requests, so back-to-back requests need no forwarding.
// A pop of an empty stack and a peek of a bad position return -1, while
// push and nop return 0; every result carries the count (low five bits)
// and the empty and full flags.
// A stalled output holds its result while one more request waits in the
// access stage; input stall rises only when both are occupied.

module lifo_stack_with_peek_core #(
	parameter int DEPTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   mode,
	input  wire logic signed [31:0]           push_value,
	input  wire logic [4:0]                   peek_position,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [31:0]                read_value,
	output logic      [1:0]                   status,
	output logic      [4:0]                   entry_count,
	output logic                              is_empty,
	output logic                              is_full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic                        s1_valid;
	logic                        s1_adv;
	lswp_pkg::res_info_t         info_s1;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [lswp_pkg::WORD_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [lswp_pkg::WORD_W-1:0] mem_rdata;
	logic [lswp_pkg::WORD_W-1:0] value_w;

	lswp_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.push_value   (push_value),
		.peek_position(peek_position),
		.s1_adv       (s1_adv),
		.s1_valid_q   (s1_valid),
		.info_s1      (info_s1),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr)
	);

	lswp_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	lswp_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid),
		.info_s1    (info_s1),
		.rdata      (mem_rdata),
		.s1_adv     (s1_adv),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (value_w),
		.status     (status),
		.entry_count(entry_count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	assign read_value = signed'(value_w);

endmodule

`default_nettype wire

### design/lswp_mem.sv
// stack storage: one write port, one registered read port
`default_nettype none

module lswp_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [lswp_pkg::WORD_W-1:0] wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	output logic      [lswp_pkg::WORD_W-1:0] rdata
);

	logic [lswp_pkg::WORD_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/lswp_ctrl.sv
// request decode, fill count and memory access stage
`default_nettype none

`include "assert_macros.svh"

module lswp_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int CW    = 5
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   mode,
	input  wire logic [lswp_pkg::WORD_W-1:0]  push_value,
	input  wire logic [lswp_pkg::POS_W-1:0]   peek_position,
	input  wire logic                         s1_adv,
	output logic                              s1_valid_q,
	output lswp_pkg::res_info_t               info_s1,
	output logic                              mem_we,
	output logic      [AW-1:0]                mem_waddr,
	output logic      [lswp_pkg::WORD_W-1:0]  mem_wdata,
	output logic                              mem_re,
	output logic      [AW-1:0]                mem_raddr
);

	localparam int PW = (CW > lswp_pkg::POS_W) ? CW : lswp_pkg::POS_W;

	lswp_pkg::mode_e_t   mode_w;
	lswp_pkg::res_info_t info_w;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_nxt;
	logic [PW-1:0]       cnt_ext;
	logic [PW-1:0]       pos_ext;
	logic                in_fire;
	logic                full_w;
	logic                empty_w;

	assign mode_w   = lswp_pkg::mode_e_t'(mode);
	assign in_stall = s1_valid_q & ~s1_adv;
	assign in_fire  = in_valid & ~in_stall;
	assign full_w   = (count_q == CW'(DEPTH));
	assign empty_w  = (count_q == '0);
	assign cnt_ext  = PW'(count_q);
	assign pos_ext  = PW'(peek_position);
	assign mem_wdata = push_value;

	// decode the request against the current count
	always_comb begin
		count_nxt      = count_q;
		mem_we         = 1'b0;
		mem_re         = 1'b0;
		mem_waddr      = AW'(count_q);
		mem_raddr      = AW'(count_q - CW'(1));
		info_w.use_mem = 1'b0;
		info_w.status  = lswp_pkg::ST_OK;
		unique case (mode_w)
			lswp_pkg::MODE_PUSH: begin
				if (full_w) begin
					info_w.status = lswp_pkg::ST_OVERFLOW;
				end else begin
					mem_we    = in_fire;
					count_nxt = count_q + CW'(1);
				end
			end
			lswp_pkg::MODE_POP: begin
				if (empty_w) begin
					info_w.status = lswp_pkg::ST_UNDERFLOW;
				end else begin
					mem_re         = in_fire;
					info_w.use_mem = 1'b1;
					count_nxt      = count_q - CW'(1);
				end
			end
			lswp_pkg::MODE_PEEK: begin
				if (pos_ext == '0 || pos_ext > cnt_ext) begin
					info_w.status = lswp_pkg::ST_BADPOS;
				end else begin
					mem_re         = in_fire;
					mem_raddr      = AW'(cnt_ext - pos_ext);
					info_w.use_mem = 1'b1;
				end
			end
			lswp_pkg::MODE_NOP: begin
				info_w.status = lswp_pkg::ST_OK;
			end
			default: begin
				info_w.status = lswp_pkg::ST_OK;
			end
		endcase
		info_w.count = lswp_pkg::COUNT_W'(count_nxt);
		info_w.empty = (count_nxt == '0);
		info_w.full  = (count_nxt == CW'(DEPTH));
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_fire) begin
			count_q <= count_nxt;
		end
	end

	// access stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_fire | (s1_valid_q & ~s1_adv);
		end
	end

	// access stage info
	always_ff @(posedge clk) begin
		if (in_fire) begin
			info_s1 <= info_w;
		end
	end

	`LSWP_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "fill count above depth")
	`LSWP_ASSERT(a_push_inc,
		in_fire && mode_w == lswp_pkg::MODE_PUSH && !full_w |=> count_q == $past(count_q) + CW'(1),
		"push did not grow the count")
	`LSWP_ASSERT(a_pop_dec,
		in_fire && mode_w == lswp_pkg::MODE_POP && !empty_w |=> count_q == $past(count_q) - CW'(1),
		"pop did not shrink the count")
	`LSWP_ASSERT_NEVER(a_rw_excl, mem_we && mem_re, "memory written and read by one request")

endmodule

`default_nettype wire

### design/lswp_out.sv
// output register: forms the read value and holds the result until transfer
`default_nettype none

module lswp_out (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s1_valid,
	input  wire lswp_pkg::res_info_t          info_s1,
	input  wire logic [lswp_pkg::WORD_W-1:0]  rdata,
	output logic                              s1_adv,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [lswp_pkg::WORD_W-1:0]  read_value,
	output logic      [1:0]                   status,
	output logic      [lswp_pkg::COUNT_W-1:0] entry_count,
	output logic                              is_empty,
	output logic                              is_full
);

	logic                        load;
	logic [lswp_pkg::WORD_W-1:0] value_w;
	logic [lswp_pkg::WORD_W-1:0] value_q;
	lswp_pkg::res_info_t         info_q;

	assign s1_adv = ~out_valid | ~out_stall;
	assign load   = s1_valid & s1_adv;

	// memory word, error word or zero
	always_comb begin
		if (info_s1.use_mem) begin
			value_w = rdata;
		end else if (info_s1.status == lswp_pkg::ST_UNDERFLOW ||
				info_s1.status == lswp_pkg::ST_BADPOS) begin
			value_w = lswp_pkg::ERR_WORD;
		end else begin
			value_w = '0;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= value_w;
			info_q  <= info_s1;
		end
	end

	assign read_value  = value_q;
	assign status      = info_q.status;
	assign entry_count = info_q.count;
	assign is_empty    = info_q.empty;
	assign is_full     = info_q.full;

endmodule

`default_nettype wire
